FILE: rtl/btp_pkg.sv
package btp_pkg;

  localparam int ADDR_BITS     = 48;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int TAG_W         = ADDR_BITS - IDX_W;
  localparam int CNT_W         = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX           = CNT_W'(4);
  localparam logic [CNT_W-1:0] COUNT_INSTALL_TAKEN = CNT_W'(3);
  localparam logic [CNT_W-1:0] COUNT_TAKEN_ABOVE   = CNT_W'(1);

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] branch_addr;
    logic                 was_taken;
    logic [ADDR_BITS-1:0] actual_target;
  } in_item_t;

  typedef struct packed {
    logic                 predict_taken;
    logic [ADDR_BITS-1:0] predict_target;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [ADDR_BITS-1:0] target;
    logic [CNT_W-1:0]     count;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;   // write one zero entry of the clearing pass
    logic cap;   // capture the input transfer and read its entry
    logic exe;   // resolve the captured item
  } btp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_predict;
    logic out_busy;
  } btp_stat_t;

endpackage

FILE: rtl/btp_ctrl.sv
module btp_ctrl
  import btp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  btp_stat_t stat,
  output btp_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // A prediction waits until the output register can take its result.
        if (!stat.is_predict || !stat.out_busy) begin
          cmd.exe   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/btp_datapath.sv
module btp_datapath
  import btp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  btp_cmd_t  cmd,
  output btp_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_r;
  in_item_t         in_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [IDX_W-1:0] cur_idx;
  logic [TAG_W-1:0] cur_tag;
  logic             hit;
  entry_t           upd;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  out_item_t        pred;

  assign cur_idx = in_r.branch_addr[IDX_W-1:0];
  assign cur_tag = in_r.branch_addr[ADDR_BITS-1:IDX_W];
  assign hit     = (rd_r.tag == cur_tag) && (rd_r.target != '0);

  always_comb begin
    upd = rd_r;
    if (!hit) begin
      upd.tag    = cur_tag;
      upd.target = in_r.actual_target;
      upd.count  = in_r.was_taken ? COUNT_INSTALL_TAKEN : '0;
    end else if (in_r.was_taken && (rd_r.target == in_r.actual_target)) begin
      if (rd_r.count < COUNT_MAX) upd.count = rd_r.count + CNT_W'(1);
    end else if (rd_r.count != '0) begin
      upd.count = rd_r.count - CNT_W'(1);
    end else begin
      upd.target = in_r.actual_target;
    end
  end

  always_comb begin
    pred.predict_taken  = hit && (rd_r.count > COUNT_TAKEN_ABOVE);
    pred.predict_target = hit ? rd_r.target : '0;
  end

  assign we = cmd.clr || (cmd.exe && (in_r.op == OP_UPDATE));
  assign wa = cmd.clr ? clr_cnt_r : cur_idx;
  assign wd = cmd.clr ? '0 : upd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.cap) rd_r <= mem[in_data.branch_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) in_r <= in_data;
    if (cmd.exe && (in_r.op == OP_PREDICT)) out_r <= pred;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cmd.exe && (in_r.op == OP_PREDICT)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last   = (clr_cnt_r == IDX_W'(TABLE_ENTRIES - 1));
  assign stat.is_predict = (in_r.op == OP_PREDICT);
  assign stat.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/branch_target_predictor_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_data (in_item_t)
// out      output     out_valid/out_stall  out_data (out_item_t)
//
// Each item is first captured and its table entry read from the single-port
// memory, then resolved; for an update the entry is then written back.
// After reset a clearing pass zeroes all TABLE_ENTRIES (1024) table entries,
// one entry a cycle, holding in_stall high until the pass is done.
// A prediction waits in its resolve step while the previous result is
// stalled in the output register; updates never wait on the output side.
module branch_target_predictor_core
  import btp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  btp_cmd_t  cmd;
  btp_stat_t stat;

  btp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  btp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/btp_checker.sv
module btp_checker
  import btp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // The clearing pass keeps the input side stalled straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // The input side stays stalled while an accepted item is being resolved.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A new result only comes out of a resolve step, during which the input side is stalled.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind branch_target_predictor_core btp_checker u_btp_checker (.*);
